/* hdl/nhpc_pkg.sv */
package nhpc_pkg;

  localparam int unsigned KEY_W       = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [31:0] FNV_BASIS = 32'h811C9DC5;
  localparam logic [31:0] FNV_PRIME = 32'h01000193;
  localparam logic [31:0] FMIX_C1   = 32'h85ebca6b;
  localparam logic [31:0] FMIX_C2   = 32'hc2b2ae35;

  localparam logic [2:0] PAL_RESET = 3'd3;
  localparam logic [2:0] PAL_LAST  = 3'd6;

  typedef enum logic [1:0] {
    CMD_ABSORB = 2'd0,
    CMD_FINISH = 2'd1,
    CMD_WINDOW = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] key;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [2:0] pal_clamp(input logic [2:0] sel);
    pal_clamp = (sel > PAL_LAST) ? PAL_LAST : sel;
  endfunction

  function automatic logic [3:0] pal_len(input logic [2:0] sel);
    case (pal_clamp(sel))
      3'd0:    pal_len = 4'd8;
      3'd1:    pal_len = 4'd6;
      3'd2:    pal_len = 4'd6;
      3'd3:    pal_len = 4'd10;
      3'd4:    pal_len = 4'd8;
      3'd5:    pal_len = 4'd7;
      default: pal_len = 4'd5;
    endcase
  endfunction

  function automatic logic [31:0] pal_color(input logic [2:0] sel, input logic [3:0] idx);
    logic [31:0] c;
    c = 32'h0;
    case ({pal_clamp(sel), idx})
      {3'd0, 4'd0}: c = 32'hffff2d95;
      {3'd0, 4'd1}: c = 32'hff00d9ff;
      {3'd0, 4'd2}: c = 32'hffffd400;
      {3'd0, 4'd3}: c = 32'hff7c3aff;
      {3'd0, 4'd4}: c = 32'hff00e676;
      {3'd0, 4'd5}: c = 32'hffff6b00;
      {3'd0, 4'd6}: c = 32'hffff1744;
      {3'd0, 4'd7}: c = 32'hff00b8d4;
      {3'd1, 4'd0}: c = 32'hfff50057;
      {3'd1, 4'd1}: c = 32'hff00e5ff;
      {3'd1, 4'd2}: c = 32'hffc6ff00;
      {3'd1, 4'd3}: c = 32'hff651fff;
      {3'd1, 4'd4}: c = 32'hff1de9b6;
      {3'd1, 4'd5}: c = 32'hffff9100;
      {3'd2, 4'd0}: c = 32'hffe8175d;
      {3'd2, 4'd1}: c = 32'hff0fb9b1;
      {3'd2, 4'd2}: c = 32'hfffec230;
      {3'd2, 4'd3}: c = 32'hff5f27cd;
      {3'd2, 4'd4}: c = 32'hff10ac84;
      {3'd2, 4'd5}: c = 32'hffee5a24;
      {3'd3, 4'd0}: c = 32'hffd1495b;
      {3'd3, 4'd1}: c = 32'hff4e8098;
      {3'd3, 4'd2}: c = 32'hffedae49;
      {3'd3, 4'd3}: c = 32'hff7c9885;
      {3'd3, 4'd4}: c = 32'hff9b6a8f;
      {3'd3, 4'd5}: c = 32'hffe8846b;
      {3'd3, 4'd6}: c = 32'hff3f7d6e;
      {3'd3, 4'd7}: c = 32'hffc46a4e;
      {3'd3, 4'd8}: c = 32'hff6d7ba8;
      {3'd3, 4'd9}: c = 32'hffb8935f;
      {3'd4, 4'd0}: c = 32'hfff08ca4;
      {3'd4, 4'd1}: c = 32'hff7fc6c4;
      {3'd4, 4'd2}: c = 32'hffffc978;
      {3'd4, 4'd3}: c = 32'hffb08ed4;
      {3'd4, 4'd4}: c = 32'hff8fce90;
      {3'd4, 4'd5}: c = 32'hffff9f7a;
      {3'd4, 4'd6}: c = 32'hff8ab6f0;
      {3'd4, 4'd7}: c = 32'hffe5a3d0;
      {3'd5, 4'd0}: c = 32'hff4a6b52;
      {3'd5, 4'd1}: c = 32'hff7d8f5c;
      {3'd5, 4'd2}: c = 32'hff3f6b6e;
      {3'd5, 4'd3}: c = 32'hff8a7248;
      {3'd5, 4'd4}: c = 32'hff5c6b8a;
      {3'd5, 4'd5}: c = 32'hff6b5344;
      {3'd5, 4'd6}: c = 32'hff2f5e4a;
      {3'd6, 4'd0}: c = 32'hff9aa0a6;
      {3'd6, 4'd1}: c = 32'hff7c8288;
      {3'd6, 4'd2}: c = 32'hffb4bac0;
      {3'd6, 4'd3}: c = 32'hff686e74;
      {3'd6, 4'd4}: c = 32'hff8d939a;
      default:      c = 32'h0;
    endcase
    pal_color = c;
  endfunction

endpackage

/* hdl/nhpc_front.sv */
module nhpc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_cmd,
  input  logic [7:0]       in_name_byte,
  input  logic [31:0]      in_window_id,
  input  nhpc_pkg::q_stat_t q_stat,
  output nhpc_pkg::push_t  push
);
  import nhpc_pkg::*;

  logic [31:0] hash_r, hash_nxt;
  logic        accept;
  logic [7:0]  lc;
  logic [31:0] mixed;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  // fold A-Z to lower case
  assign lc    = (in_name_byte >= 8'h41 && in_name_byte <= 8'h5a) ?
                 in_name_byte + 8'h20 : in_name_byte;
  assign mixed = (hash_r ^ {24'h0, lc}) * FNV_PRIME;

  always_comb begin
    hash_nxt   = hash_r;
    push.valid = 1'b0;
    push.key   = hash_r;
    if (accept) begin
      case (cmd_t'(in_cmd))
        CMD_ABSORB: begin
          if (in_name_byte != 8'h00) hash_nxt = mixed;
        end
        CMD_FINISH: begin
          push.valid = 1'b1;
          hash_nxt   = FNV_BASIS;
        end
        CMD_WINDOW: begin
          push.valid = 1'b1;
          push.key   = in_window_id;
        end
        default: begin
          hash_nxt = hash_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= FNV_BASIS;
    end else begin
      hash_r <= hash_nxt;
    end
  end

endmodule

/* hdl/nhpc_queue.sv */
module nhpc_queue #(
  parameter int unsigned DEPTH = nhpc_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  nhpc_pkg::push_t   push,
  input  logic              pop,
  output nhpc_pkg::q_stat_t q_stat,
  output logic [31:0]       head_key
);
  import nhpc_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [31:0]   mem [DEPTH];
  logic [31:0]   head_r;
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign q_stat.full  = (cnt_r == CNT_FULL);
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push.valid && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_key     = head_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  // head register follows the next read slot; forward a transaction landing there
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push.key;
    if (do_push && (wr_ptr_r == rd_ptr_nxt)) head_r <= push.key;
    else head_r <= mem[rd_ptr_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* hdl/nhpc_back.sv */
module nhpc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  nhpc_pkg::q_stat_t q_stat,
  input  logic [31:0]       head_key,
  output logic              pop,
  input  logic [2:0]        pal_sel,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_color,
  output logic [3:0]        out_palette_index
);
  import nhpc_pkg::*;

  localparam int unsigned STEPS = KEY_W / 2;
  localparam int unsigned SW    = $clog2(STEPS);
  localparam logic [SW-1:0] STEP_LAST = SW'(STEPS - 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL1 = 6'b000010,
    S_MUL2 = 6'b000100,
    S_MIX3 = 6'b001000,
    S_MOD  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t        state_r, state_nxt;
  logic [31:0]   x_r, x_nxt;
  logic [3:0]    rem_r, rem_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   color_r, color_nxt;
  logic [3:0]    idx_r, idx_nxt;
  logic [3:0]    len;
  logic [5:0]    t0, t1, t2;
  logic [31:0]   x13;
  logic          slot_free;

  assign len       = pal_len(pal_sel);
  assign slot_free = !out_valid_r || !out_stall;
  assign pop       = (state_r == S_IDLE) && !q_stat.empty;
  assign x13       = x_r ^ (x_r >> 13);

  // radix-4 remainder step: rem = (4*rem + digit) mod len
  assign t0 = {rem_r, 2'b00} + {4'h0, x_r[31:30]};
  assign t1 = (t0 >= {1'b0, len, 1'b0}) ? t0 - {1'b0, len, 1'b0} : t0;
  assign t2 = (t1 >= {2'b00, len}) ? t1 - {2'b00, len} : t1;

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    color_nxt     = color_r;
    idx_nxt       = idx_r;
    case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          x_nxt     = head_key ^ (head_key >> 16);
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        x_nxt     = x_r * FMIX_C1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        x_nxt     = x13 * FMIX_C2;
        state_nxt = S_MIX3;
      end
      S_MIX3: begin
        x_nxt     = x_r ^ (x_r >> 16);
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        rem_nxt = t2[3:0];
        x_nxt   = {x_r[29:0], 2'b00};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == STEP_LAST) state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          color_nxt     = pal_color(pal_sel, rem_r);
          idx_nxt       = rem_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    color_r <= color_nxt;
    idx_r   <= idx_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_color         = color_r;
  assign out_palette_index = idx_r;

endmodule

/* hdl/name_hash_palette_color.sv */
// Name-hash palette color picker.
// Input channel (in_valid / in_stall): in_cmd selects absorb of in_name_byte
// into the running FNV-1a hash, finish of the name, or a direct lookup for
// in_window_id. Absorb gives no result; finish and window lookup each give one
// transaction on the output channel (out_color, out_palette_index).
// The front absorbs name bytes at one per cycle while in_stall is low and hands
// finished keys to a two-entry queue; in_stall rises only while that queue is full.
// The back takes one key at a time: it picks a key up in S_IDLE with the first
// xor-shift of the murmur3 finalizer, finishes the finalizer in S_MUL1, S_MUL2
// and S_MIX3 (two constant multiplies), takes the radix-4 remainder by the
// palette length in S_MOD, and loads the output register in S_OUT once it is free.
// The palette is chosen by register 0 (palette_select) on the cfg_ APB port.
// Reset returns the hash to the offset basis, palette_select to 3, empties the
// queue and drops any pending result.
// While out_stall is high the result holds on the output; the back then
// waits, the queue fills, and in_stall follows once it is full.
module name_hash_palette_color #(
  parameter int unsigned QUEUE_DEPTH = nhpc_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_name_byte,
  input  logic [31:0] in_window_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_color,
  output logic [3:0]  out_palette_index,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import nhpc_pkg::*;

  push_t       push;
  q_stat_t     q_stat;
  logic        pop;
  logic [31:0] head_key;
  logic [2:0]  pal_sel_r, pal_sel_nxt;
  logic        reg0_hit;

  assign cfg_pready = 1'b1;
  assign reg0_hit   = (cfg_paddr[2] == 1'b0);
  assign cfg_prdata = reg0_hit ? {29'h0, pal_sel_r} : 32'h0;

  always_comb begin
    pal_sel_nxt = pal_sel_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && reg0_hit) pal_sel_nxt = cfg_pwdata[2:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_sel_r <= PAL_RESET;
    end else begin
      pal_sel_r <= pal_sel_nxt;
    end
  end

  nhpc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_name_byte (in_name_byte),
    .in_window_id (in_window_id),
    .q_stat       (q_stat),
    .push         (push)
  );

  nhpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop      (pop),
    .q_stat   (q_stat),
    .head_key (head_key)
  );

  nhpc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_stat            (q_stat),
    .head_key          (head_key),
    .pop               (pop),
    .pal_sel           (pal_sel_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_color         (out_color),
    .out_palette_index (out_palette_index)
  );

endmodule
